// File: sv/owrs_pkg.sv
// shared types and constants for the 1-wire rom search controller
package owrs_pkg;

  localparam int MaxDevicesDef = 16;
  localparam int ByteBits      = 8;
  localparam int RomBits       = 64;
  localparam int BitNumW       = 7;

  localparam logic [7:0] SearchByte = 8'hF0;

  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_BUSDONE = 2'd1;
  localparam logic [1:0] REQ_TRIPLET = 2'd2;

  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_RESET_BUS   = 3'd1;
  localparam logic [2:0] CMD_SEARCH_BYTE = 3'd2;
  localparam logic [2:0] CMD_TRIPLET     = 3'd3;
  localparam logic [2:0] CMD_ROM_FOUND   = 3'd4;
  localparam logic [2:0] CMD_FINISHED    = 3'd5;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RESET_WAIT,
    PH_SEARCH_WAIT,
    PH_TRIPLET_WAIT
  } phase_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic       first_bit;
    logic       complement_bit;
    logic       taken_direction;
  } req_t;

  typedef struct packed {
    logic [2:0]  command;
    logic        direction;
    logic [63:0] rom_value;
    logic [3:0]  rom_index;
    logic        no_response;
    logic        last_of_run;
  } rsp_t;

  typedef struct packed {
    logic [1:0] push_cnt;
    rsp_t       first;
    rsp_t       second;
  } push_t;

endpackage

// File: sv/owrs_outq.sv
// result queue: takes up to two items a cycle, hands out one unless its output is stalled
module owrs_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  owrs_pkg::push_t push_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output owrs_pkg::rsp_t out_item_o
);
  import owrs_pkg::*;

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  rsp_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room_o      = (cnt_q <= CntW'(Depth - 2));
  assign wr_next     = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.push_cnt);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    cnt_d    = cnt_q + CntW'(push_i.push_cnt) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.push_cnt == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: sv/onewire_rom_search_controller.sv
// 1-wire search-rom controller top level: input register, search logic, result queue
// path: an accepted item is held in the input register and processed when the queue
//   has room; its results are written into the queue, from which they are offered
// throughput unless stalled: one item per cycle, set by the single-pass search logic;
//   the output moves one result per cycle, so two-result items drain at that rate
// reset: asynchronous, clears the search state to idle and empties the result queue
module onewire_rom_search_controller #(
  parameter int MaxDevices = owrs_pkg::MaxDevicesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  owrs_pkg::req_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output owrs_pkg::rsp_t out_item_o
);
  import owrs_pkg::*;

  localparam int CntW = $clog2(MaxDevices + 1);

  function automatic logic pick_dir(input logic [BitNumW-1:0] n,
                                    input logic [BitNumW-1:0] ld,
                                    input logic [RomBits-1:0] bits);
    logic [BitNumW-1:0] nm1;
    logic               d;
    nm1 = n - BitNumW'(1);
    if (n < ld) begin
      d = bits[nm1[5:0]];
    end else begin
      d = (n == ld);
    end
    return d;
  endfunction

  function automatic logic [RomBits-1:0] rom_order(input logic [RomBits-1:0] bits);
    logic [RomBits-1:0] v;
    v = '0;
    for (int i = 0; i < RomBits / ByteBits; i++) begin
      v[RomBits-1-ByteBits*i -: ByteBits] = bits[ByteBits*i +: ByteBits];
    end
    return v;
  endfunction

  // input register
  logic in_valid_q;
  req_t in_q;
  logic room;
  logic fire;

  // search state
  phase_e             phase_q, phase_d;
  logic [RomBits-1:0] rom_q, rom_d;
  logic [BitNumW-1:0] bit_q, bit_d;
  logic [BitNumW-1:0] lzp_q, lzp_d;
  logic [BitNumW-1:0] ld_q, ld_d;
  logic               lds_q, lds_d;
  logic [CntW-1:0]    fc_q, fc_d;

  // helpers
  logic               is_start, is_done_rst, is_done_srch, is_trip;
  logic               both_ones, zero_disc, pass_end, search_over;
  logic [BitNumW-1:0] bit_m1, bit_inc, lzp_end;
  logic [RomBits-1:0] rom_upd, rom_end;
  logic [CntW-1:0]    fc_inc;
  logic [CntW+3:0]    fc_ext;
  push_t              push;

  assign in_stall_o = in_valid_q && !room;
  assign fire       = in_valid_q && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  assign is_start     = fire && (in_q.req_type == REQ_START);
  assign is_done_rst  = fire && (in_q.req_type == REQ_BUSDONE) && (phase_q == PH_RESET_WAIT);
  assign is_done_srch = fire && (in_q.req_type == REQ_BUSDONE) && (phase_q == PH_SEARCH_WAIT);
  assign is_trip      = fire && (in_q.req_type == REQ_TRIPLET) && (phase_q == PH_TRIPLET_WAIT);

  assign both_ones = in_q.first_bit && in_q.complement_bit;
  assign zero_disc = !in_q.first_bit && !in_q.complement_bit && !in_q.taken_direction;
  assign bit_m1    = bit_q - BitNumW'(1);
  assign bit_inc   = bit_q + BitNumW'(1);

  always_comb begin
    rom_upd = rom_q;
    rom_upd[bit_m1[5:0]] = in_q.taken_direction;
  end

  assign rom_end     = both_ones ? rom_q : rom_upd;
  assign lzp_end     = (both_ones || !zero_disc) ? lzp_q : bit_q;
  assign pass_end    = is_trip && (both_ones || (bit_inc > BitNumW'(RomBits)));
  assign fc_inc      = fc_q + CntW'(1);
  assign search_over = (fc_inc >= CntW'(MaxDevices)) || lds_q || (lzp_end == '0);
  assign fc_ext      = {4'b0000, fc_q};

  // next state
  always_comb begin
    phase_d = phase_q;
    rom_d   = rom_q;
    bit_d   = bit_q;
    lzp_d   = lzp_q;
    ld_d    = ld_q;
    lds_d   = lds_q;
    fc_d    = fc_q;
    priority if (is_start) begin
      ld_d    = '0;
      lds_d   = 1'b0;
      fc_d    = '0;
      bit_d   = BitNumW'(1);
      lzp_d   = '0;
      phase_d = PH_RESET_WAIT;
    end else if (is_done_rst) begin
      phase_d = PH_SEARCH_WAIT;
    end else if (is_done_srch) begin
      phase_d = PH_TRIPLET_WAIT;
    end else if (pass_end) begin
      rom_d = rom_end;
      ld_d  = lzp_end;
      lds_d = lds_q || (lzp_end == '0);
      fc_d  = fc_inc;
      if (search_over) begin
        bit_d   = both_ones ? bit_q : bit_inc;
        lzp_d   = lzp_end;
        phase_d = PH_IDLE;
      end else begin
        bit_d   = BitNumW'(1);
        lzp_d   = '0;
        phase_d = PH_RESET_WAIT;
      end
    end else if (is_trip) begin
      rom_d = rom_upd;
      lzp_d = lzp_end;
      bit_d = bit_inc;
    end else begin
      phase_d = phase_q;
    end
  end

  // results
  always_comb begin
    push          = '0;
    push.push_cnt = 2'd0;
    priority if (is_start) begin
      push.push_cnt          = 2'd1;
      push.first.command     = CMD_RESET_BUS;
      push.first.last_of_run = 1'b1;
    end else if (is_done_rst) begin
      push.push_cnt          = 2'd1;
      push.first.command     = CMD_SEARCH_BYTE;
      push.first.rom_value   = RomBits'(SearchByte);
      push.first.last_of_run = 1'b1;
    end else if (is_done_srch) begin
      push.push_cnt          = 2'd1;
      push.first.command     = CMD_TRIPLET;
      push.first.direction   = pick_dir(bit_q, ld_q, rom_q);
      push.first.last_of_run = 1'b1;
    end else if (pass_end) begin
      push.push_cnt           = 2'd2;
      push.first.command      = CMD_ROM_FOUND;
      push.first.rom_value    = rom_order(rom_end);
      push.first.rom_index    = fc_ext[3:0];
      push.first.no_response  = both_ones;
      push.second.command     = search_over ? CMD_FINISHED : CMD_RESET_BUS;
      push.second.last_of_run = 1'b1;
    end else if (is_trip) begin
      push.push_cnt          = 2'd1;
      push.first.command     = CMD_TRIPLET;
      push.first.direction   = pick_dir(bit_inc, ld_q, rom_upd);
      push.first.last_of_run = 1'b1;
    end else begin
      push.first.command = CMD_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rom_q   <= '0;
      bit_q   <= BitNumW'(1);
      lzp_q   <= '0;
      ld_q    <= '0;
      lds_q   <= 1'b0;
      fc_q    <= '0;
    end else begin
      phase_q <= phase_d;
      rom_q   <= rom_d;
      bit_q   <= bit_d;
      lzp_q   <= lzp_d;
      ld_q    <= ld_d;
      lds_q   <= lds_d;
      fc_q    <= fc_d;
    end
  end

  owrs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_start |=> (phase_q == PH_RESET_WAIT) && (fc_q == '0) && (ld_q == '0))
    else $error("start item did not restart the search");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_TRIPLET_WAIT) |-> (bit_q != '0) && (bit_q <= BitNumW'(RomBits)))
    else $error("bit number out of range during triplets");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= CntW'(MaxDevices))
    else $error("found count beyond device limit");

  a_pass_end_leaves_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pass_end |=> (phase_q == PH_IDLE) || (phase_q == PH_RESET_WAIT))
    else $error("pass end did not leave the triplet wait");

endmodule
